FILE: rtl/bziq_pkg.sv
// Package for the balanced zone input qualifier.
// Holds the transaction types, configuration codes and level/state helper functions.
// No dependencies.
`timescale 1ns / 1ps

package bziq_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int MIN_FILTER_MS = 50;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int TIME_W        = 16;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_DIGITAL  = 2'd1,
        MODE_BALANCED = 2'd2,
        MODE_RESERVED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_SHORT   = 3'd0,
        ST_NORMAL  = 3'd1,
        ST_ALARM   = 3'd2,
        ST_BREAK   = 3'd3,
        ST_UNKNOWN = 3'd4
    } zone_state_t;

    localparam logic [2:0] LVL_UNREAD = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHANNEL_SETUP   = 4'd0,
        REG_THRESHOLD_1     = 4'd1,
        REG_THRESHOLD_2     = 4'd2,
        REG_THRESHOLD_3     = 4'd3,
        REG_FILTER_TIME     = 4'd4,
        REG_DELAY_ON        = 4'd5,
        REG_DELAY_OFF       = 4'd6,
        REG_TAMPER_DELAY_ON = 4'd7
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] adc_sample;
        logic [31:0]            now_ms;
    } in_t;

    typedef struct packed {
        logic [2:0] zone_state;
        logic       state_changed;
        logic       drive_outputs;
    } out_t;

    typedef struct packed {
        logic [9:0]             channel_setup;
        logic [SAMPLE_BITS-1:0] threshold_1;
        logic [SAMPLE_BITS-1:0] threshold_2;
        logic [SAMPLE_BITS-1:0] threshold_3;
        logic [TIME_W-1:0]      filter_time;
        logic [TIME_W-1:0]      delay_on;
        logic [TIME_W-1:0]      delay_off;
        logic [TIME_W-1:0]      tamper_delay_on;
    } cfg_t;

    function automatic logic [2:0] state_of_level(input logic [2:0] lvl,
                                                  input logic [9:0] setup);
        logic [2:0] st;
        st = ST_UNKNOWN;
        case (lvl)
            3'd0:    st = {1'b0, setup[3:2]};
            3'd1:    st = {1'b0, setup[5:4]};
            3'd2:    st = {1'b0, setup[7:6]};
            3'd3:    st = {1'b0, setup[9:8]};
            default: st = ST_UNKNOWN;
        endcase
        return st;
    endfunction

    function automatic logic [TIME_W:0] hold_time(input logic [2:0] from_st,
                                                  input logic [2:0] to_st,
                                                  input cfg_t cfg);
        logic [TIME_W-1:0] base;
        logic [TIME_W:0]   need;
        logic              to_tamper;
        base = (cfg.filter_time < TIME_W'(MIN_FILTER_MS)) ?
               TIME_W'(MIN_FILTER_MS) : cfg.filter_time;
        to_tamper = (to_st == ST_SHORT) || (to_st == ST_BREAK);
        need = {1'b0, base};
        if (from_st == to_st) begin
            need = '0;
        end else if ((from_st == ST_NORMAL || from_st == ST_ALARM) && to_tamper) begin
            need = {1'b0, base} + {1'b0, cfg.tamper_delay_on};
        end else if (from_st == ST_NORMAL && to_st == ST_ALARM) begin
            need = {1'b0, base} + {1'b0, cfg.delay_on};
        end else if (from_st == ST_ALARM && to_st == ST_NORMAL) begin
            need = {1'b0, base} + {1'b0, cfg.delay_off};
        end
        return need;
    endfunction

endpackage

FILE: rtl/balanced_zone_input_qualifier_top.sv
// Top level of the balanced zone input qualifier.
// Holds the input register, level sorting, hold timer and result register.
// Depends on bziq_pkg and bziq_cfg_regs.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-------------------------------
//   in      | in_valid / in_stall   | in_data  (adc_sample, now_ms)
//   out     | out_valid / out_stall | out_data (state, changed, drive)
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction is accepted per cycle while the output is not stalled; each gives its
// result through the input register and then the result register, around the
// combinational level, timer and acceptance logic.
// Reset clears the zone state to unknown and arms forced acceptance.
// A stall on the output holds the result and backs up into in_stall.
`timescale 1ns / 1ps

module balanced_zone_input_qualifier_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  bziq_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output bziq_pkg::out_t                    out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bziq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bziq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bziq_pkg::*;

    cfg_t       cfg;
    logic       cfg_write;

    logic       in_valid_reg;
    in_t        in_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_t       out_data_reg;
    out_t       out_data_next;

    logic [2:0]  cur_level_reg;
    logic [2:0]  cur_level_next;
    logic [2:0]  acc_level_reg;
    logic [2:0]  acc_level_next;
    logic [31:0] stamp_reg;
    logic [31:0] stamp_next;
    logic        force_reg;
    logic        force_next;
    logic        drive_reg;
    logic        drive_next;

    logic        advance;
    logic [1:0]  mode;
    logic [2:0]  lvl;
    logic [2:0]  from_st;
    logic [2:0]  to_st;
    logic [TIME_W:0] need;
    logic [31:0] elapsed;
    logic        changed;

    bziq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_write (cfg_write)
    );

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign mode      = cfg.channel_setup[1:0];

    always_comb
    begin
        cur_level_next = cur_level_reg;
        acc_level_next = acc_level_reg;
        stamp_next     = stamp_reg;
        force_next     = force_reg;
        drive_next     = drive_reg;
        changed        = 1'b0;
        lvl            = 3'd3;
        from_st        = ST_UNKNOWN;
        to_st          = ST_UNKNOWN;
        need           = '0;
        elapsed        = '0;

        if (mode == MODE_DIGITAL)
        begin
            lvl = (cfg.threshold_1 > in_data_reg.adc_sample) ? 3'd0 : 3'd1;
        end
        else if (cfg.threshold_1 > in_data_reg.adc_sample)
        begin
            lvl = 3'd0;
        end
        else if (cfg.threshold_2 > in_data_reg.adc_sample)
        begin
            lvl = 3'd1;
        end
        else if (cfg.threshold_3 > in_data_reg.adc_sample)
        begin
            lvl = 3'd2;
        end

        if (in_valid_reg && advance && (mode == MODE_DIGITAL || mode == MODE_BALANCED))
        begin
            if (lvl != cur_level_reg)
            begin
                cur_level_next = lvl;
                stamp_next     = in_data_reg.now_ms;
            end
            if (cur_level_next != acc_level_reg)
            begin
                from_st = state_of_level(acc_level_reg, cfg.channel_setup);
                to_st   = state_of_level(cur_level_next, cfg.channel_setup);
                need    = hold_time(from_st, to_st, cfg);
                elapsed = in_data_reg.now_ms - stamp_next;
                if (elapsed >= 32'(need) || force_reg)
                begin
                    acc_level_next = cur_level_next;
                    force_next     = 1'b0;
                    changed        = 1'b1;
                    if (to_st == ST_NORMAL)
                    begin
                        drive_next = 1'b0;
                    end
                    if (to_st == ST_ALARM)
                    begin
                        drive_next = 1'b1;
                    end
                end
            end
        end

        if (cfg_write)
        begin
            force_next = 1'b1;
        end

        out_data_next.zone_state    = state_of_level(acc_level_next, cfg.channel_setup);
        out_data_next.state_changed = changed;
        out_data_next.drive_outputs = drive_next;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_level_reg <= LVL_UNREAD;
            acc_level_reg <= LVL_UNREAD;
            stamp_reg     <= '0;
            force_reg     <= 1'b1;
            drive_reg     <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            cur_level_reg <= cur_level_next;
            acc_level_reg <= acc_level_next;
            stamp_reg     <= stamp_next;
            force_reg     <= force_next;
            drive_reg     <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: rtl/bziq_cfg_regs.sv
// Configuration register file of the balanced zone input qualifier.
// Decodes write transactions and flags every write for forced acceptance.
// Depends on bziq_pkg.
`timescale 1ns / 1ps

module bziq_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bziq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bziq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bziq_pkg::cfg_t                     cfg,
    output logic                               cfg_write
);
    import bziq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_SETUP:   cfg_next.channel_setup   = cfg_data[9:0];
                REG_THRESHOLD_1:     cfg_next.threshold_1     = cfg_data[SAMPLE_BITS-1:0];
                REG_THRESHOLD_2:     cfg_next.threshold_2     = cfg_data[SAMPLE_BITS-1:0];
                REG_THRESHOLD_3:     cfg_next.threshold_3     = cfg_data[SAMPLE_BITS-1:0];
                REG_FILTER_TIME:     cfg_next.filter_time     = cfg_data[TIME_W-1:0];
                REG_DELAY_ON:        cfg_next.delay_on        = cfg_data[TIME_W-1:0];
                REG_DELAY_OFF:       cfg_next.delay_off       = cfg_data[TIME_W-1:0];
                REG_TAMPER_DELAY_ON: cfg_next.tamper_delay_on = cfg_data[TIME_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_setup   <= '0;
            cfg_reg.threshold_1     <= SAMPLE_BITS'(1024);
            cfg_reg.threshold_2     <= SAMPLE_BITS'(2048);
            cfg_reg.threshold_3     <= SAMPLE_BITS'(3072);
            cfg_reg.filter_time     <= TIME_W'(50);
            cfg_reg.delay_on        <= '0;
            cfg_reg.delay_off       <= '0;
            cfg_reg.tamper_delay_on <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
